### hdl/rrss_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrss_pkg
// Shared types and constants for the round-robin sleep scheduler.
// ---------------------------------------------------------------------------
package rrss_pkg;

  localparam int ID_BITS         = 16;
  localparam int MS_W            = 16;
  localparam int TPM_W           = 10;
  // sleep_ms times ticks_per_ms never exceeds MS_W + TPM_W bits
  localparam int SLEEP_W         = MS_W + TPM_W;
  localparam int DEF_MAX_THREADS = 8;

  localparam logic [TPM_W-1:0] TPM_RESET = 10'd32;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_SPAWN = 2'd1;
  localparam logic [1:0] KIND_SLEEP = 2'd2;
  localparam logic [1:0] KIND_EXIT  = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_IDLE = 2'd2;

  typedef struct packed {
    logic [1:0]      kind;
    logic [MS_W-1:0] sleep_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ID_BITS-1:0] running_id;
    logic [2:0]         running_slot;
    logic [ID_BITS-1:0] new_id;
    logic [3:0]         thread_count;
  } out_word_t;

  typedef struct packed {
    logic load_id;
    logic load_sleep;
    logic shift;
    logic dec;
  } cell_ctrl_t;

endpackage

### hdl/round_robin_sleep_scheduler_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// round_robin_sleep_scheduler_unit
// Round-robin thread scheduler with per-thread sleep counters held in a
// chain of slot cells.
// ---------------------------------------------------------------------------
//  channel | direction | handshake         | word
//  in_     | input     | in_valid/in_stall | kind, sleep_ms
//  out_    | output    | out_valid/out_stall | status, ids, slot, count
//  cfg_    | input     | cfg_valid/cfg_ready | ticks_per_ms (10 bits)
//
// After acceptance, spawn and exit pass from execute to emit; sleep passes
// execute (multiply), write (slot write) and emit; tick passes execute, a
// scan over the slots' awake flags (one slot a cycle from the search start,
// at most thread count slots) and emit. Reset is synchronous; cfg_ready is
// always high. A result waits in the output register; while it is stalled the
// next result holds in the emit state and no further word is accepted.
// ---------------------------------------------------------------------------
module round_robin_sleep_scheduler_unit #(
  parameter int MAX_THREADS = rrss_pkg::DEF_MAX_THREADS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  rrss_pkg::in_word_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output rrss_pkg::out_word_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rrss_pkg::TPM_W-1:0] cfg_data
);

  localparam int IDX_W   = $clog2(MAX_THREADS);
  localparam int CNT_W   = $clog2(MAX_THREADS + 1);
  localparam int ID_BITS = rrss_pkg::ID_BITS;
  localparam int SLEEP_W = rrss_pkg::SLEEP_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_WRITE = 5'b00100,
    S_SCAN  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [1:0]                 kind_r, kind_nxt;
  logic [rrss_pkg::MS_W-1:0]  ms_r, ms_nxt;
  logic [SLEEP_W-1:0]         prod_r, prod_nxt;
  logic [CNT_W-1:0]           live_r, live_nxt;
  logic [IDX_W-1:0]           run_r, run_nxt;
  logic [CNT_W-1:0]           ss_r, ss_nxt;
  logic [ID_BITS-1:0]         next_id_r, next_id_nxt;
  logic                       exit_r, exit_nxt;
  logic [IDX_W-1:0]           scan_pos_r, scan_pos_nxt;
  logic [CNT_W-1:0]           scan_cnt_r, scan_cnt_nxt;
  logic [1:0]                 status_r, status_nxt;
  logic [ID_BITS-1:0]         given_r, given_nxt;
  logic [rrss_pkg::TPM_W-1:0] tpm_r;
  logic                       out_valid_r, out_valid_nxt;
  rrss_pkg::out_word_t        out_data_r;

  rrss_pkg::cell_ctrl_t       cell_ctrl [MAX_THREADS];
  logic [ID_BITS-1:0]         cell_id   [MAX_THREADS];
  logic [SLEEP_W-1:0]         cell_sleep[MAX_THREADS];
  logic [ID_BITS-1:0]         nb_id     [MAX_THREADS];
  logic [SLEEP_W-1:0]         nb_sleep  [MAX_THREADS];
  logic [MAX_THREADS-1:0]     awake;
  logic [ID_BITS-1:0]         wr_id;
  logic [SLEEP_W-1:0]         wr_sleep;

  logic                       do_remove;
  logic                       full;
  logic [CNT_W-1:0]           live_tick;
  logic [CNT_W-1:0]           ss_eff;
  logic [IDX_W-1:0]           scan_start;
  logic [CNT_W-1:0]           pos_inc;
  logic                       emit_fire;
  logic [63:0]                slot_ext;
  logic [63:0]                count_ext;
  rrss_pkg::out_word_t        emit_word;

  // ---- slot chain ----
  for (genvar g = 0; g < MAX_THREADS; g++) begin : g_cell
    if (g == MAX_THREADS - 1) begin : g_top
      assign nb_id[g]    = '0;
      assign nb_sleep[g] = '0;
    end else begin : g_mid
      assign nb_id[g]    = cell_id[g+1];
      assign nb_sleep[g] = cell_sleep[g+1];
    end

    rrss_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl[g]),
      .wr_id    (wr_id),
      .wr_sleep (wr_sleep),
      .nb_id    (nb_id[g]),
      .nb_sleep (nb_sleep[g]),
      .id       (cell_id[g]),
      .sleep    (cell_sleep[g]),
      .awake    (awake[g])
    );
  end

  // ---- shared decode ----
  assign do_remove  = exit_r && (live_r > CNT_W'(1));
  assign full       = (live_r >= CNT_W'(MAX_THREADS));
  assign live_tick  = do_remove ? live_r - 1'b1 : live_r;
  assign ss_eff     = do_remove ? CNT_W'(run_r) : ss_r;
  assign scan_start = (ss_eff < live_tick) ? ss_eff[IDX_W-1:0] : '0;
  assign pos_inc    = CNT_W'(scan_pos_r) + 1'b1;
  assign emit_fire  = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  assign wr_id    = next_id_r;
  assign wr_sleep = (state_r == S_WRITE) ? prod_r : '0;

  always_comb begin
    for (int i = 0; i < MAX_THREADS; i++) begin
      cell_ctrl[i].dec        = (state_r == S_EXEC) && (kind_r == rrss_pkg::KIND_TICK);
      cell_ctrl[i].shift      = (state_r == S_EXEC) && (kind_r == rrss_pkg::KIND_TICK) &&
                                do_remove && (IDX_W'(i) >= run_r);
      cell_ctrl[i].load_id    = (state_r == S_EXEC) && (kind_r == rrss_pkg::KIND_SPAWN) &&
                                !full && (CNT_W'(i) == live_r);
      cell_ctrl[i].load_sleep = cell_ctrl[i].load_id ||
                                ((state_r == S_WRITE) && (IDX_W'(i) == run_r));
    end
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    ms_nxt       = ms_r;
    prod_nxt     = prod_r;
    live_nxt     = live_r;
    run_nxt      = run_r;
    ss_nxt       = ss_r;
    next_id_nxt  = next_id_r;
    exit_nxt     = exit_r;
    scan_pos_nxt = scan_pos_r;
    scan_cnt_nxt = scan_cnt_r;
    status_nxt   = status_r;
    given_nxt    = given_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt   = in_data.kind;
          ms_nxt     = in_data.sleep_ms;
          status_nxt = rrss_pkg::STATUS_OK;
          given_nxt  = '0;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        case (kind_r)
          rrss_pkg::KIND_TICK: begin
            // cells drop the marked slot and count down this cycle
            if (do_remove) begin
              live_nxt = live_tick;
              ss_nxt   = CNT_W'(run_r);
              run_nxt  = (CNT_W'(run_r) < live_tick) ? run_r : '0;
            end
            exit_nxt     = 1'b0;
            scan_pos_nxt = scan_start;
            scan_cnt_nxt = '0;
            state_nxt    = S_SCAN;
          end
          rrss_pkg::KIND_SPAWN: begin
            if (full) begin
              status_nxt = rrss_pkg::STATUS_FULL;
            end else begin
              given_nxt   = next_id_r;
              live_nxt    = live_r + 1'b1;
              next_id_nxt = next_id_r + 1'b1;
            end
            state_nxt = S_EMIT;
          end
          rrss_pkg::KIND_SLEEP: begin
            prod_nxt  = SLEEP_W'(ms_r) * SLEEP_W'(tpm_r);
            state_nxt = S_WRITE;
          end
          default: begin
            if (live_r > CNT_W'(1)) begin
              exit_nxt = 1'b1;
            end
            state_nxt = S_EMIT;
          end
        endcase
      end
      S_WRITE: begin
        state_nxt = S_EMIT;
      end
      S_SCAN: begin
        if (awake[scan_pos_r]) begin
          run_nxt   = scan_pos_r;
          ss_nxt    = pos_inc;
          state_nxt = S_EMIT;
        end else if (scan_cnt_r == live_r - 1'b1) begin
          status_nxt = rrss_pkg::STATUS_IDLE;
          state_nxt  = S_EMIT;
        end else begin
          // advance round the live slots, wrapping to slot 0
          scan_pos_nxt = (pos_inc >= live_r) ? '0 : pos_inc[IDX_W-1:0];
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      live_r    <= CNT_W'(1);
      run_r     <= '0;
      ss_r      <= CNT_W'(1);
      next_id_r <= ID_BITS'(1);
      exit_r    <= 1'b0;
      tpm_r     <= rrss_pkg::TPM_RESET;
    end else begin
      state_r   <= state_nxt;
      live_r    <= live_nxt;
      run_r     <= run_nxt;
      ss_r      <= ss_nxt;
      next_id_r <= next_id_nxt;
      exit_r    <= exit_nxt;
      if (cfg_valid && cfg_ready) begin
        tpm_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    ms_r       <= ms_nxt;
    prod_r     <= prod_nxt;
    scan_pos_r <= scan_pos_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    status_r   <= status_nxt;
    given_r    <= given_nxt;
  end

  // ---- output register ----
  assign slot_ext  = 64'(run_r);
  assign count_ext = 64'(live_r);

  always_comb begin
    emit_word.status       = status_r;
    emit_word.running_id   = cell_id[run_r];
    emit_word.running_slot = slot_ext[2:0];
    emit_word.new_id       = given_r;
    emit_word.thread_count = count_ext[3:0];
  end

  always_comb begin
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data_r <= emit_word;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

### hdl/rrss_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrss_cell
// One thread slot: id and sleep count, loaded, decremented, or taken from
// the next slot up when a thread leaves the table.
// ---------------------------------------------------------------------------
module rrss_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rrss_pkg::cell_ctrl_t        ctrl,
  input  logic [rrss_pkg::ID_BITS-1:0] wr_id,
  input  logic [rrss_pkg::SLEEP_W-1:0] wr_sleep,
  input  logic [rrss_pkg::ID_BITS-1:0] nb_id,
  input  logic [rrss_pkg::SLEEP_W-1:0] nb_sleep,
  output logic [rrss_pkg::ID_BITS-1:0] id,
  output logic [rrss_pkg::SLEEP_W-1:0] sleep,
  output logic                        awake
);

  logic [rrss_pkg::ID_BITS-1:0] id_r, id_nxt;
  logic [rrss_pkg::SLEEP_W-1:0] sleep_r, sleep_nxt;

  always_comb begin
    id_nxt    = id_r;
    sleep_nxt = sleep_r;
    if (ctrl.load_id || ctrl.load_sleep) begin
      if (ctrl.load_id) begin
        id_nxt = wr_id;
      end
      if (ctrl.load_sleep) begin
        sleep_nxt = wr_sleep;
      end
    end else if (ctrl.shift) begin
      // take the neighbour's word, counting down on the way
      id_nxt    = nb_id;
      sleep_nxt = (nb_sleep != '0) ? nb_sleep - 1'b1 : '0;
    end else if (ctrl.dec && sleep_r != '0) begin
      sleep_nxt = sleep_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r    <= '0;
      sleep_r <= '0;
    end else begin
      id_r    <= id_nxt;
      sleep_r <= sleep_nxt;
    end
  end

  assign id    = id_r;
  assign sleep = sleep_r;
  assign awake = (sleep_r == '0);

endmodule

### bench/rrss_sched_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrss_sched_checker
// Watches the scheduler's channels, keeps its own thread table in step with
// every accepted request word and compares each accepted result word, field
// by field, against the oldest predicted answer.
// ---------------------------------------------------------------------------
module rrss_sched_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  rrss_pkg::in_word_t         in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  rrss_pkg::out_word_t        out_data,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [rrss_pkg::TPM_W-1:0] cfg_data,
  input  logic                       run_end,
  output int                         errors,
  output int                         results,
  output int                         full_count,
  output int                         idle_count
);

  localparam int SLOTS = rrss_pkg::DEF_MAX_THREADS;

  // model of the thread table
  logic [rrss_pkg::ID_BITS-1:0] slot_id    [SLOTS];
  logic [31:0]                  slot_ticks [SLOTS];
  int unsigned                  n_threads;
  int unsigned                  cur_slot;
  int unsigned                  scan_from;
  logic [rrss_pkg::ID_BITS-1:0] id_next;
  bit                           leave_pending;
  logic [rrss_pkg::TPM_W-1:0]   tick_rate;

  rrss_pkg::out_word_t answer_q [$];
  bit                  end_seen;

  initial begin
    errors     = 0;
    results    = 0;
    full_count = 0;
    idle_count = 0;
    end_seen   = 1'b0;
  end

  function automatic void clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      slot_id[i]    = '0;
      slot_ticks[i] = '0;
    end
    n_threads     = 1;
    cur_slot      = 0;
    scan_from     = 1;
    id_next       = 1;
    leave_pending = 1'b0;
    tick_rate     = rrss_pkg::TPM_RESET;
  endfunction

  // Drop a marked thread, count every sleeper down, then look for the
  // first awake thread from the scan position, wrapping.
  function automatic logic [1:0] timer_tick();
    int unsigned pos;
    if (leave_pending && n_threads > 1) begin
      for (int unsigned i = cur_slot; i + 1 < n_threads; i++) begin
        slot_id[i]    = slot_id[i+1];
        slot_ticks[i] = slot_ticks[i+1];
      end
      slot_id[n_threads-1]    = '0;
      slot_ticks[n_threads-1] = '0;
      n_threads--;
      scan_from = cur_slot;
      if (cur_slot >= n_threads) cur_slot = 0;
    end
    leave_pending = 1'b0;
    for (int unsigned i = 0; i < n_threads; i++)
      if (slot_ticks[i] != 0) slot_ticks[i]--;
    pos = (scan_from < n_threads) ? scan_from : 0;
    for (int unsigned i = 0; i < n_threads; i++) begin
      if (slot_ticks[pos] == 0) begin
        cur_slot  = pos;
        scan_from = pos + 1;
        return rrss_pkg::STATUS_OK;
      end
      pos++;
      if (pos >= n_threads) pos = 0;
    end
    return rrss_pkg::STATUS_IDLE;
  endfunction

  function automatic rrss_pkg::out_word_t schedule_word(rrss_pkg::in_word_t w);
    rrss_pkg::out_word_t r;
    logic [63:0]         prod;
    r = '0;
    r.status = rrss_pkg::STATUS_OK;
    case (w.kind)
      rrss_pkg::KIND_TICK: r.status = timer_tick();
      rrss_pkg::KIND_SPAWN: begin
        if (n_threads >= SLOTS) begin
          r.status = rrss_pkg::STATUS_FULL;
        end else begin
          r.new_id              = id_next;
          slot_id[n_threads]    = id_next;
          slot_ticks[n_threads] = '0;
          n_threads++;
          id_next = id_next + 1'b1;
        end
      end
      rrss_pkg::KIND_SLEEP: begin
        prod = 64'(w.sleep_ms) * 64'(tick_rate);
        if (prod > 64'hFFFF_FFFF) prod = 64'hFFFF_FFFF;
        slot_ticks[cur_slot] = prod[31:0];
      end
      rrss_pkg::KIND_EXIT: if (n_threads > 1) leave_pending = 1'b1;
      default: ;
    endcase
    r.running_id   = slot_id[cur_slot];
    r.running_slot = cur_slot[2:0];
    r.thread_count = n_threads[3:0];
    return r;
  endfunction

  function automatic void report(string what);
    errors++;
    $display("%0t ERROR: %s", $time, what);
  endfunction

  function automatic void compare_field(string name, logic [31:0] exp, logic [31:0] got);
    if (got !== exp)
      report($sformatf("%s mismatch, expected %0d, actual %0d", name, exp, got));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_table();
      answer_q.delete();
    end else begin
      // compare before predicting: an answer never leaves on the edge its word enters
      if (out_valid && !out_stall) begin
        results++;
        if (answer_q.size() == 0) begin
          report($sformatf("result word with nothing expected, expected none, actual %h",
                           out_data));
        end else begin
          rrss_pkg::out_word_t exp;
          exp = answer_q.pop_front();
          compare_field("status", 32'(exp.status), 32'(out_data.status));
          compare_field("running_id", 32'(exp.running_id), 32'(out_data.running_id));
          compare_field("running_slot", 32'(exp.running_slot), 32'(out_data.running_slot));
          compare_field("new_id", 32'(exp.new_id), 32'(out_data.new_id));
          compare_field("thread_count", 32'(exp.thread_count), 32'(out_data.thread_count));
          if (exp.status == rrss_pkg::STATUS_FULL) full_count++;
          if (exp.status == rrss_pkg::STATUS_IDLE) idle_count++;
        end
      end
      if (cfg_valid && cfg_ready) tick_rate = cfg_data;
      if (in_valid && !in_stall) answer_q.push_back(schedule_word(in_data));
      if (run_end && !end_seen) begin
        end_seen = 1'b1;
        if (answer_q.size() != 0)
          report($sformatf("%0d expected result words never arrived, expected %h, actual none",
                           answer_q.size(), answer_q[0]));
      end
    end
  end

endmodule

### bench/tb_round_robin_sleep_scheduler_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_round_robin_sleep_scheduler_unit
// Drives scheduler requests (tick, spawn, sleep, exit) through a directed
// opening and randomised phases at several tick rates, with random idling
// on both channels and one long output hold-off; the checker beside the
// block predicts and compares every result word.
// ---------------------------------------------------------------------------
module tb_round_robin_sleep_scheduler_unit;

  localparam int HALF_PERIOD = 4;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  rrss_pkg::in_word_t         in_data;
  logic                       out_valid;
  logic                       out_stall;
  rrss_pkg::out_word_t        out_data;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [rrss_pkg::TPM_W-1:0] cfg_data;
  logic                       run_end;

  int          errors;
  int          results;
  int          full_count;
  int          idle_count;
  int unsigned words_sent = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;

  always #(HALF_PERIOD) clk = ~clk;

  round_robin_sleep_scheduler_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  rrss_sched_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .run_end    (run_end),
    .errors     (errors),
    .results    (results),
    .full_count (full_count),
    .idle_count (idle_count)
  );

  // idling regime follows progress: sender light / receiver heavy, swapped, none
  function automatic int unsigned sender_gap_pct();
    if (words_sent < 450) return 21;
    if (words_sent < 900) return 67;
    return 0;
  endfunction

  function automatic int unsigned receiver_gap_pct();
    if (words_sent < 450) return 67;
    if (words_sent < 900) return 21;
    return 0;
  endfunction

  // receiver; one long hold-off so the block fills and stalls its input
  always @(posedge clk) begin
    if (!hold_done && words_sent >= 500) begin
      hold_done = 1'b1;
      hold_left = 400;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_gap_pct());
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic send_word(input logic [1:0] kind, input logic [rrss_pkg::MS_W-1:0] ms);
    rrss_pkg::in_word_t w;
    w.kind     = kind;
    w.sleep_ms = ms;
    if ($urandom_range(99) < sender_gap_pct()) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_gap_pct());
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic write_tick_rate(input logic [rrss_pkg::TPM_W-1:0] rate);
    in_valid <= 1'b0;
    while (results != words_sent) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= rate;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [rrss_pkg::MS_W-1:0] pick_ms();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return rrss_pkg::MS_W'($urandom_range(3));
    if (r < 90) return rrss_pkg::MS_W'($urandom_range(255));
    return rrss_pkg::MS_W'($urandom());
  endfunction

  task automatic random_phase(input int unsigned count, input int unsigned spawn_pct);
    int unsigned r;
    logic [1:0]  kind;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < spawn_pct)           kind = rrss_pkg::KIND_SPAWN;
      else if (r < spawn_pct + 20) kind = rrss_pkg::KIND_SLEEP;
      else if (r < spawn_pct + 32) kind = rrss_pkg::KIND_EXIT;
      else                         kind = rrss_pkg::KIND_TICK;
      send_word(kind, pick_ms());
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    run_end   <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening at the reset tick rate
    send_word(rrss_pkg::KIND_TICK, 16'd0);
    send_word(rrss_pkg::KIND_EXIT, 16'd0);        // last thread: ignored
    send_word(rrss_pkg::KIND_TICK, 16'd0);
    send_word(rrss_pkg::KIND_SLEEP, 16'hFFFF);
    send_word(rrss_pkg::KIND_TICK, 16'd0);        // lone thread asleep
    repeat (7) send_word(rrss_pkg::KIND_SPAWN, 16'd0);
    send_word(rrss_pkg::KIND_SPAWN, 16'h5A5A);    // table full
    send_word(rrss_pkg::KIND_TICK, 16'd0);
    send_word(rrss_pkg::KIND_SLEEP, 16'hFFFF);
    send_word(rrss_pkg::KIND_EXIT, 16'd0);
    send_word(rrss_pkg::KIND_TICK, 16'd0);
    send_word(rrss_pkg::KIND_SLEEP, 16'd1);
    send_word(rrss_pkg::KIND_EXIT, 16'd0);
    send_word(rrss_pkg::KIND_TICK, 16'd0);
    send_word(rrss_pkg::KIND_TICK, 16'd0);
    send_word(rrss_pkg::KIND_SLEEP, 16'd0);
    send_word(rrss_pkg::KIND_TICK, 16'd0);

    write_tick_rate(10'd1);
    random_phase(220, 20);
    write_tick_rate(10'd1023);
    random_phase(150, 15);
    write_tick_rate(10'd0);
    random_phase(150, 20);
    write_tick_rate(10'd2);
    random_phase(200, 25);
    write_tick_rate(10'd1000);
    random_phase(150, 12);
    write_tick_rate(rrss_pkg::TPM_W'($urandom_range(1000, 1)));
    random_phase(150, 20);
    write_tick_rate(10'd1);
    random_phase(230, 18);

    in_valid <= 1'b0;
    while (results != words_sent) @(posedge clk);
    repeat (30) @(posedge clk);
    run_end <= 1'b1;
    repeat (3) @(posedge clk);

    $display("Sent %0d scheduler words over seven tick rates, 0 and 1023 included.",
             words_sent);
    $display("Answers seen: %0d table full, %0d all threads asleep.", full_count, idle_count);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
